[design/tts_pkg.sv]
// ----------------------------------------------------------------------------
// Trapezoid setpoint package
// Shared widths, register indices, reset values and segment codes.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TEMP_W     = 19;
    localparam int RATE_W     = 20;
    localparam int HOLD_W     = 27;
    localparam int SLOPE_W    = 21;
    localparam int SEG_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam int SCALE      = 10000;
    localparam int NUM_W      = 33;
    localparam int PER_W      = 35;
    localparam int PROD_W     = 53;
    localparam int LO_W       = 17;

    // The scale of 10000 is 16 * 625; the factor 625 is removed by a
    // multiplication with the rounded-up reciprocal 2^39 / 625.
    localparam int SCALE_PRE  = 4;
    localparam int SCALE_POST = 39;
    localparam int RECIP_W    = 30;
    localparam int QIN_W      = NUM_W - SCALE_PRE;
    localparam int QPROD_W    = QIN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SCALE_RECIP = 30'd879609303;

    localparam int TIME_BITS_DEFAULT = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_TEMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_TEMP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TEMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_HOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_HOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ON  = 3'd7;

    localparam logic signed [TEMP_W-1:0] UPPER_TEMP_RST = 19'sd10000;
    localparam logic signed [TEMP_W-1:0] LOWER_TEMP_RST = 19'sd2500;
    localparam logic signed [TEMP_W-1:0] START_TEMP_RST = 19'sd2500;
    localparam logic [RATE_W-1:0]        RISE_RATE_RST  = 20'd1000;
    localparam logic [RATE_W-1:0]        FALL_RATE_RST  = 20'd1000;

    localparam logic [SEG_W-1:0] SEG_RISE       = 3'd0;
    localparam logic [SEG_W-1:0] SEG_UPPER_HOLD = 3'd1;
    localparam logic [SEG_W-1:0] SEG_FALL       = 3'd2;
    localparam logic [SEG_W-1:0] SEG_LOWER_HOLD = 3'd3;
    localparam logic [SEG_W-1:0] SEG_FINAL_HOLD = 3'd4;

endpackage

[design/tts_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a side vector and a valid bit
// that travel alongside the operands.
// ----------------------------------------------------------------------------
module tts_div #(
    parameter int NW = tts_pkg::NUM_W,
    parameter int DW = tts_pkg::RATE_W,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    localparam int W = DW + NW;

    logic [W-1:0]  acc_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];
    logic          vld_reg  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [W-1:0]  src_acc;
        logic [DW-1:0] src_den;
        logic [SW-1:0] src_side;
        logic          src_vld;
        logic [W-1:0]  acc_next;

        if (i == 0) begin : g_first
            assign src_acc  = {{DW{1'b0}}, in_num};
            assign src_den  = in_den;
            assign src_side = in_side;
            assign src_vld  = in_valid;
        end else begin : g_rest
            assign src_acc  = acc_reg[i-1];
            assign src_den  = den_reg[i-1];
            assign src_side = side_reg[i-1];
            assign src_vld  = vld_reg[i-1];
        end

        always_comb begin
            logic [W:0]  sh;
            logic [DW:0] top;
            logic [DW:0] diff;
            sh   = {src_acc, 1'b0};
            top  = sh[W:NW];
            diff = top - {1'b0, src_den};
            if (top >= {1'b0, src_den}) begin
                acc_next = {diff[DW-1:0], sh[NW-1:1], 1'b1};
            end else begin
                acc_next = {top[DW-1:0], sh[NW-1:1], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[i]  <= acc_next;
                den_reg[i]  <= src_den;
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = acc_reg[NW-1][NW-1:0];
    assign out_rem   = acc_reg[NW-1][W-1:NW];
    assign out_side  = side_reg[NW-1];

endmodule

[design/trapezoid_temperature_setpoint_core.sv]
// ----------------------------------------------------------------------------
// Trapezoid temperature setpoint core
// Maps elapsed program time to setpoint, slope, time to the next corner,
// segment target and segment index of a trapezoid heating program.
// ----------------------------------------------------------------------------
// The core takes one beat per clock while the output is not stalled and
// returns one result beat per input beat, in order. Each beat passes
// through two chains of one-bit-per-stage dividers: the ramp durations
// over the rates and the reduction of time into the repeat period.
// The ramp step is scaled by a shift and a reciprocal multiplication. The
// whole pipeline advances when the output register is empty or being taken.
// Configuration must only be written while no beat is in flight.
module trapezoid_temperature_setpoint_core #(
    parameter int TIME_BITS = tts_pkg::TIME_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [TIME_BITS-1:0]               s_elapsed_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tts_pkg::TEMP_W-1:0]  m_setpoint,
    output logic signed [tts_pkg::SLOPE_W-1:0] m_slope,
    output logic [TIME_BITS-1:0]               m_time_to_corner,
    output logic signed [tts_pkg::TEMP_W-1:0]  m_segment_target,
    output logic [tts_pkg::SEG_W-1:0]          m_segment
);

    localparam int TEMP_W     = tts_pkg::TEMP_W;
    localparam int RATE_W     = tts_pkg::RATE_W;
    localparam int HOLD_W     = tts_pkg::HOLD_W;
    localparam int SLOPE_W    = tts_pkg::SLOPE_W;
    localparam int SEG_W      = tts_pkg::SEG_W;
    localparam int NUM_W      = tts_pkg::NUM_W;
    localparam int PER_W      = tts_pkg::PER_W;
    localparam int PROD_W     = tts_pkg::PROD_W;
    localparam int LO_W       = tts_pkg::LO_W;
    localparam int HI_W       = NUM_W - LO_W;
    localparam int SCALE_PRE  = tts_pkg::SCALE_PRE;
    localparam int SCALE_POST = tts_pkg::SCALE_POST;
    localparam int QPROD_W    = tts_pkg::QPROD_W;
    localparam int XW         = (TIME_BITS > PER_W) ? TIME_BITS : PER_W;

    typedef struct packed {
        logic              in_first;
        logic              per_zero;
        logic [PER_W-1:0]  ct;
        logic [PER_W-1:0]  len;
        logic [NUM_W-1:0]  c1;
        logic [NUM_W-1:0]  cf;
    } mod_side_t;

    typedef struct packed {
        logic [SEG_W-1:0]     seg;
        logic                 in_first;
        logic [TIME_BITS-1:0] ttc;
    } step_side_t;

    // Configuration registers.
    logic signed [TEMP_W-1:0] upper_reg, lower_reg, start_reg;
    logic [RATE_W-1:0]        rise_reg, fall_reg;
    logic [HOLD_W-1:0]        uhold_reg, lhold_reg;
    logic                     repeat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg  <= tts_pkg::UPPER_TEMP_RST;
            lower_reg  <= tts_pkg::LOWER_TEMP_RST;
            start_reg  <= tts_pkg::START_TEMP_RST;
            rise_reg   <= tts_pkg::RISE_RATE_RST;
            fall_reg   <= tts_pkg::FALL_RATE_RST;
            uhold_reg  <= '0;
            lhold_reg  <= '0;
            repeat_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tts_pkg::REG_UPPER_TEMP: upper_reg  <= cfg_data[TEMP_W-1:0];
                tts_pkg::REG_LOWER_TEMP: lower_reg  <= cfg_data[TEMP_W-1:0];
                tts_pkg::REG_START_TEMP: start_reg  <= cfg_data[TEMP_W-1:0];
                tts_pkg::REG_RISE_RATE:  rise_reg   <= cfg_data[RATE_W-1:0];
                tts_pkg::REG_FALL_RATE:  fall_reg   <= cfg_data[RATE_W-1:0];
                tts_pkg::REG_UPPER_HOLD: uhold_reg  <= cfg_data[HOLD_W-1:0];
                tts_pkg::REG_LOWER_HOLD: lhold_reg  <= cfg_data[HOLD_W-1:0];
                tts_pkg::REG_REPEAT_ON:  repeat_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [RATE_W-1:0] rise_eff, fall_eff;
    assign rise_eff = (rise_reg == '0) ? RATE_W'(1) : rise_reg;
    assign fall_eff = (fall_reg == '0) ? RATE_W'(1) : fall_reg;

    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Input stage.
    logic                 v0_reg;
    logic [TIME_BITS-1:0] t0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= s_elapsed_ms;
        end
    end

    // Ramp duration numerators, 10000 * |to - from|.
    logic signed [TEMP_W:0] diff_first, diff_main;
    logic [TEMP_W-1:0]      mag_first, mag_main;
    logic [NUM_W-1:0]       num_first, num_main;

    always_comb begin
        diff_first = $signed({upper_reg[TEMP_W-1], upper_reg})
                   - $signed({start_reg[TEMP_W-1], start_reg});
        diff_main  = $signed({upper_reg[TEMP_W-1], upper_reg})
                   - $signed({lower_reg[TEMP_W-1], lower_reg});
        mag_first  = diff_first[TEMP_W] ? TEMP_W'(-diff_first) : diff_first[TEMP_W-1:0];
        mag_main   = diff_main[TEMP_W] ? TEMP_W'(-diff_main) : diff_main[TEMP_W-1:0];
        num_first  = NUM_W'(mag_first) * NUM_W'(tts_pkg::SCALE);
        num_main   = NUM_W'(mag_main) * NUM_W'(tts_pkg::SCALE);
    end

    logic                 v1a, v1b, v1c;
    logic [NUM_W-1:0]     c1f_q, c1p_q, cf_q;
    logic [TIME_BITS-1:0] t1;
    logic [RATE_W-1:0]    rem_a, rem_b, rem_c;
    logic                 side_b, side_c;

    tts_div #(.NW(NUM_W), .DW(RATE_W), .SW(TIME_BITS)) u_div_first (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg), .in_num(num_first), .in_den(rise_eff), .in_side(t0_reg),
        .out_valid(v1a), .out_quo(c1f_q), .out_rem(rem_a), .out_side(t1)
    );

    tts_div #(.NW(NUM_W), .DW(RATE_W), .SW(1)) u_div_rise (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg), .in_num(num_main), .in_den(rise_eff), .in_side(1'b0),
        .out_valid(v1b), .out_quo(c1p_q), .out_rem(rem_b), .out_side(side_b)
    );

    tts_div #(.NW(NUM_W), .DW(RATE_W), .SW(1)) u_div_fall (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg), .in_num(num_main), .in_den(fall_eff), .in_side(1'b0),
        .out_valid(v1c), .out_quo(cf_q), .out_rem(rem_c), .out_side(side_c)
    );

    // Program lengths.
    logic                 vd_reg;
    logic [TIME_BITS-1:0] td_reg;
    logic [PER_W-1:0]     first_reg, period_reg;
    logic [NUM_W-1:0]     c1f_reg, c1p_reg, cf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= v1a && v1b && v1c;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            td_reg     <= t1;
            first_reg  <= PER_W'(c1f_q) + PER_W'(uhold_reg) + PER_W'(cf_q)
                        + PER_W'(lhold_reg);
            period_reg <= PER_W'(c1p_q) + PER_W'(uhold_reg) + PER_W'(cf_q)
                        + PER_W'(lhold_reg);
            c1f_reg    <= c1f_q;
            c1p_reg    <= c1p_q;
            cf_reg     <= cf_q;
        end
    end

    logic                 d_in_first;
    logic [TIME_BITS-1:0] d_mod_num;
    logic [PER_W-1:0]     d_mod_den;
    mod_side_t            d_side;

    always_comb begin
        d_in_first      = XW'(td_reg) < XW'(first_reg);
        d_mod_num       = td_reg - TIME_BITS'(first_reg);
        d_mod_den       = (period_reg == '0) ? PER_W'(1) : period_reg;
        d_side.in_first = d_in_first;
        d_side.per_zero = (period_reg == '0);
        d_side.ct       = PER_W'(td_reg);
        d_side.len      = d_in_first ? first_reg : period_reg;
        d_side.c1       = d_in_first ? c1f_reg : c1p_reg;
        d_side.cf       = cf_reg;
    end

    logic                 vm;
    logic [TIME_BITS-1:0] mod_quo;
    logic [PER_W-1:0]     mod_rem;
    logic [$bits(mod_side_t)-1:0] mod_side_bits;
    mod_side_t            m_side;

    tts_div #(.NW(TIME_BITS), .DW(PER_W), .SW($bits(mod_side_t))) u_div_mod (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vd_reg), .in_num(d_mod_num), .in_den(d_mod_den), .in_side(d_side),
        .out_valid(vm), .out_quo(mod_quo), .out_rem(mod_rem), .out_side(mod_side_bits)
    );

    assign m_side = mod_side_t'(mod_side_bits);

    // Time into the cycle.
    logic             vf_reg, f_in_first_reg, f_final_reg, f_unused_reg;
    logic [PER_W-1:0] f_ct_reg, f_len_reg;
    logic [NUM_W-1:0] f_c1_reg, f_cf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= vm;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_in_first_reg <= m_side.in_first;
            f_final_reg    <= !m_side.in_first && !repeat_reg;
            f_unused_reg   <= ^mod_quo;
            if (m_side.in_first) begin
                f_ct_reg <= m_side.ct;
            end else if (m_side.per_zero) begin
                f_ct_reg <= '0;
            end else begin
                f_ct_reg <= mod_rem;
            end
            f_len_reg <= m_side.len;
            f_c1_reg  <= m_side.c1;
            f_cf_reg  <= m_side.cf;
        end
    end

    // Corner times.
    logic             vg_reg, g_in_first_reg, g_final_reg;
    logic [PER_W-1:0] g_ct_reg, g_len_reg, g_c1_reg, g_c2_reg, g_c3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (en) begin
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_in_first_reg <= f_in_first_reg;
            g_final_reg    <= f_final_reg;
            g_ct_reg       <= f_ct_reg;
            g_len_reg      <= f_len_reg;
            g_c1_reg       <= PER_W'(f_c1_reg);
            g_c2_reg       <= PER_W'(f_c1_reg) + PER_W'(uhold_reg);
            g_c3_reg       <= PER_W'(f_c1_reg) + PER_W'(uhold_reg) + PER_W'(f_cf_reg);
        end
    end

    // Segment decision.
    logic             vh_reg, h_in_first_reg;
    logic [SEG_W-1:0] h_seg_reg, h_seg_next;
    logic [PER_W-1:0] h_corner_reg, h_corner_next, h_ct_reg;
    logic [NUM_W-1:0] h_tr_reg, h_tr_next;

    always_comb begin
        logic [PER_W-1:0] from_c2;
        from_c2 = g_ct_reg - g_c2_reg;
        if (g_ct_reg < g_c1_reg) begin
            h_seg_next    = tts_pkg::SEG_RISE;
            h_corner_next = g_c1_reg;
        end else if (g_ct_reg < g_c2_reg) begin
            h_seg_next    = tts_pkg::SEG_UPPER_HOLD;
            h_corner_next = g_c2_reg;
        end else if (g_ct_reg < g_c3_reg) begin
            h_seg_next    = tts_pkg::SEG_FALL;
            h_corner_next = g_c3_reg;
        end else begin
            h_seg_next    = tts_pkg::SEG_LOWER_HOLD;
            h_corner_next = g_len_reg;
        end
        if (g_final_reg) begin
            h_seg_next = tts_pkg::SEG_FINAL_HOLD;
        end
        h_tr_next = (h_seg_next == tts_pkg::SEG_RISE) ? NUM_W'(g_ct_reg) : NUM_W'(from_c2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
        end else if (en) begin
            vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_in_first_reg <= g_in_first_reg;
            h_seg_reg      <= h_seg_next;
            h_corner_reg   <= h_corner_next;
            h_ct_reg       <= g_ct_reg;
            h_tr_reg       <= h_tr_next;
        end
    end

    // Corner distance and partial products of the ramp step.
    logic                     vi_reg, i_in_first_reg;
    logic [SEG_W-1:0]         i_seg_reg;
    logic [PER_W-1:0]         i_ttc_reg;
    logic [LO_W+RATE_W-1:0]   i_lo_reg;
    logic [HI_W+RATE_W-1:0]   i_hi_reg;
    logic [RATE_W-1:0]        h_rate;

    assign h_rate = (h_seg_reg == tts_pkg::SEG_RISE) ? rise_eff : fall_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vi_reg <= 1'b0;
        end else if (en) begin
            vi_reg <= vh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            i_in_first_reg <= h_in_first_reg;
            i_seg_reg      <= h_seg_reg;
            i_ttc_reg      <= h_corner_reg - h_ct_reg;
            i_lo_reg       <= (LO_W+RATE_W)'(h_tr_reg[LO_W-1:0]) * (LO_W+RATE_W)'(h_rate);
            i_hi_reg       <= (HI_W+RATE_W)'(h_tr_reg[NUM_W-1:LO_W]) * (HI_W+RATE_W)'(h_rate);
        end
    end

    // Product sum and corner saturation.
    logic                 vj_reg;
    logic [PROD_W-1:0]    j_prod_reg;
    step_side_t           j_side_reg, j_side_next;

    always_comb begin
        logic [XW-1:0] ttc_x;
        logic [XW-1:0] mask_x;
        ttc_x  = XW'(i_ttc_reg);
        mask_x = XW'({TIME_BITS{1'b1}});
        j_side_next.seg      = i_seg_reg;
        j_side_next.in_first = i_in_first_reg;
        if (i_seg_reg == tts_pkg::SEG_FINAL_HOLD) begin
            j_side_next.ttc = {TIME_BITS{1'b1}};
        end else if (ttc_x >= mask_x) begin
            j_side_next.ttc = TIME_BITS'(mask_x - XW'(1));
        end else begin
            j_side_next.ttc = TIME_BITS'(ttc_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vj_reg <= 1'b0;
        end else if (en) begin
            vj_reg <= vi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j_prod_reg <= (PROD_W'(i_hi_reg) << LO_W) + PROD_W'(i_lo_reg);
            j_side_reg <= j_side_next;
        end
    end

    // Ramp step. On a ramp the product stays below 10000 * |to - from|, so it
    // fits NUM_W bits and the scaled reciprocal gives the exact quotient.
    logic                vk_reg;
    logic [QPROD_W-1:0]  k_prod_reg;
    step_side_t          k_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vk_reg <= 1'b0;
        end else if (en) begin
            vk_reg <= vj_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_prod_reg <= QPROD_W'(j_prod_reg[NUM_W-1:SCALE_PRE])
                        * QPROD_W'(tts_pkg::SCALE_RECIP);
            k_side_reg <= j_side_reg;
        end
    end

    // Output stage.
    logic signed [TEMP_W-1:0]  sp_next, tgt_next;
    logic signed [SLOPE_W-1:0] slope_next;

    always_comb begin
        logic signed [TEMP_W-1:0]  origin;
        logic signed [TEMP_W-1:0]  dest;
        logic signed [SLOPE_W-1:0] base;
        logic signed [SLOPE_W-1:0] step;
        logic signed [SLOPE_W-1:0] rate;
        logic                      up;
        if (k_side_reg.seg == tts_pkg::SEG_RISE) begin
            origin = k_side_reg.in_first ? start_reg : lower_reg;
            dest   = upper_reg;
            rate   = $signed({1'b0, rise_eff});
        end else begin
            origin = upper_reg;
            dest   = lower_reg;
            rate   = $signed({1'b0, fall_eff});
        end
        up   = dest >= origin;
        base = SLOPE_W'(origin);
        step = $signed({1'b0, k_prod_reg[QPROD_W-1:SCALE_POST]});
        case (k_side_reg.seg)
            tts_pkg::SEG_RISE, tts_pkg::SEG_FALL: begin
                sp_next    = TEMP_W'(up ? base + step : base - step);
                slope_next = up ? rate : -rate;
                tgt_next   = dest;
            end
            tts_pkg::SEG_UPPER_HOLD: begin
                sp_next    = upper_reg;
                slope_next = '0;
                tgt_next   = upper_reg;
            end
            default: begin
                sp_next    = lower_reg;
                slope_next = '0;
                tgt_next   = lower_reg;
            end
        endcase
    end

    logic                       unused_bits;
    assign unused_bits = ^{rem_a, rem_b, rem_c, side_b, side_c, f_unused_reg,
                           j_prod_reg[PROD_W-1:NUM_W], j_prod_reg[SCALE_PRE-1:0],
                           k_prod_reg[SCALE_POST-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_setpoint       <= sp_next;
            m_slope          <= slope_next;
            m_time_to_corner <= k_side_reg.ttc;
            m_segment_target <= tgt_next;
            m_segment        <= unused_bits ? k_side_reg.seg : k_side_reg.seg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
